FILE: rtl/mlfe_pkg.sv
package mlfe_pkg;

	localparam int VALUE_BITS = 32;
	localparam int OUT_BITS = 32;
	localparam int NUM_CAPS = 4;
	localparam int COL_BITS = 8;
	localparam int CFG_ADDR_BITS = 8;

	localparam logic [COL_BITS-1:0] TOKEN_MAX = '1;

	// register indexes on the configuration port
	localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_ID_COL = 8'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_ID_COL = 8'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_START_COL = 8'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_END_COL = 8'd3;

	localparam logic [COL_BITS-1:0] COL_RESET [NUM_CAPS] = '{8'd1, 8'd3, 8'd7, 8'd8};

	// saturation limit 2^(VALUE_BITS-1) and the overflow threshold pieces
	localparam logic [VALUE_BITS-1:0] SAT_LIMIT = VALUE_BITS'(1) << (VALUE_BITS - 1);
	localparam logic [VALUE_BITS-1:0] SAT_MAX = SAT_LIMIT - VALUE_BITS'(1);
	localparam logic [VALUE_BITS-1:0] SAT_QUOT = SAT_LIMIT / 10;
	localparam logic [3:0] SAT_REM = 4'(SAT_LIMIT % 10);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		PH_START,
		PH_DIGITS,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] first_id;
		logic signed [OUT_BITS-1:0] second_id;
		logic signed [OUT_BITS-1:0] seg_start;
		logic signed [OUT_BITS-1:0] seg_end;
		logic                       empty_line;
	} out_item_t;

endpackage

FILE: rtl/mlfe_if.sv
interface mlfe_in_if import mlfe_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlfe_out_if import mlfe_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlfe_cfg_if import mlfe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] addr;
	logic [COL_BITS-1:0]      data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/match_line_field_extractor.sv
// A line_end transaction is registered into item_s1, and its record is then registered into out_data_q.
// Throughput: one character transaction per cycle unless a line_end item is held
// behind an occupied output; the per-character token update (shift-add by ten
// plus saturation compare) finishes in the single stage after the input register.
// Reset: arst_n clears the token state, both valid flags and restores the column
// registers to 1, 3, 7, 8.
module match_line_field_extractor import mlfe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	mlfe_in_if.sink    in_ch,
	mlfe_out_if.source out_ch,
	mlfe_cfg_if.sink   cfg
);

	logic [COL_BITS-1:0]   col_q [NUM_CAPS];
	in_item_t              item_s1;
	logic                  valid_s1;
	logic                  adv_s1;
	logic                  in_ready;

	logic [COL_BITS-1:0]   idx_q, idx_n;
	logic [VALUE_BITS-1:0] mag_q, mag_n;
	logic                  neg_q, neg_n;
	phase_t                phase_q, phase_n;
	logic [VALUE_BITS-1:0] caps_q [NUM_CAPS];
	logic [VALUE_BITS-1:0] caps_n [NUM_CAPS];
	logic                  has_q, has_n;

	logic                  out_valid_q;
	out_item_t             out_data_q;
	out_item_t             rec;

	logic [7:0]            c;
	logic                  is_ws;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [VALUE_BITS-1:0] thresh;
	logic [VALUE_BITS-1:0] mag_x10;
	logic [VALUE_BITS-1:0] tok_val;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CAPS; k++) begin
				col_q[k] <= COL_RESET[k];
			end
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_FIRST_ID_COL:  col_q[0] <= cfg.data;
				REG_SECOND_ID_COL: col_q[1] <= cfg.data;
				REG_START_COL:     col_q[2] <= cfg.data;
				REG_END_COL:       col_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// the stage stalls only when it holds a record and the output is still occupied
	assign adv_s1 = valid_s1 && (!item_s1.line_end || !out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			item_s1 <= in_ch.data;
		end
	end

	assign c = item_s1.char_code;
	assign is_ws = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	assign is_digit = c inside {[CH_ZERO:CH_NINE]};
	assign digit = 4'(c - CH_ZERO);
	// floor((SAT_LIMIT - d) / 10) for a single digit d
	assign thresh = (digit > SAT_REM) ? SAT_QUOT - VALUE_BITS'(1) : SAT_QUOT;
	assign mag_x10 = (mag_q << 3) + (mag_q << 1);
	assign tok_val = neg_q ? (VALUE_BITS'(0) - mag_q) : ((mag_q > SAT_MAX) ? SAT_MAX : mag_q);

	always_comb begin
		idx_n = idx_q;
		mag_n = mag_q;
		neg_n = neg_q;
		phase_n = phase_q;
		has_n = has_q;
		for (int k = 0; k < NUM_CAPS; k++) begin
			caps_n[k] = caps_q[k];
		end
		if (item_s1.char_valid) begin
			has_n = 1'b1;
			if (is_ws) begin
				for (int k = 0; k < NUM_CAPS; k++) begin
					if (col_q[k] == idx_q) begin
						caps_n[k] = tok_val;
					end
				end
				if (idx_q != TOKEN_MAX) begin
					idx_n = idx_q + COL_BITS'(1);
				end
				mag_n = '0;
				neg_n = 1'b0;
				phase_n = PH_START;
			end else if (phase_q != PH_STOP) begin
				if (is_digit) begin
					if (mag_q > thresh) begin
						mag_n = SAT_LIMIT;
					end else begin
						mag_n = mag_x10 + VALUE_BITS'(digit);
					end
					phase_n = PH_DIGITS;
				end else if (phase_q == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
					neg_n = (c == CH_MINUS);
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_STOP;
				end
			end
		end
	end

	always_comb begin
		rec.empty_line = !has_n;
		rec.first_id = has_n ? OUT_BITS'(signed'(caps_n[0])) : '0;
		rec.second_id = has_n ? OUT_BITS'(signed'(caps_n[1])) : '0;
		rec.seg_start = has_n ? OUT_BITS'(signed'(caps_n[2])) : '0;
		rec.seg_end = has_n ? OUT_BITS'(signed'(caps_n[3])) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			mag_q <= '0;
			neg_q <= 1'b0;
			phase_q <= PH_START;
			has_q <= 1'b0;
			for (int k = 0; k < NUM_CAPS; k++) begin
				caps_q[k] <= '0;
			end
		end else if (adv_s1) begin
			if (item_s1.line_end) begin
				// start a fresh line
				idx_q <= '0;
				mag_q <= '0;
				neg_q <= 1'b0;
				phase_q <= PH_START;
				has_q <= 1'b0;
				for (int k = 0; k < NUM_CAPS; k++) begin
					caps_q[k] <= '0;
				end
			end else begin
				idx_q <= idx_n;
				mag_q <= mag_n;
				neg_q <= neg_n;
				phase_q <= phase_n;
				has_q <= has_n;
				for (int k = 0; k < NUM_CAPS; k++) begin
					caps_q[k] <= caps_n[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.line_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.line_end) begin
			out_data_q <= rec;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_data_q;

endmodule

FILE: rtl/mlfe_checker.sv
module mlfe_checker import mlfe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// hold a pending record until the sink takes it
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("record dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("record changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_line |-> out_data.first_id == '0 &&
		out_data.second_id == '0 && out_data.seg_start == '0 && out_data.seg_end == '0)
		else $error("empty line carries nonzero values");

	// input side may only stall behind a blocked output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind match_line_field_extractor mlfe_checker u_mlfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
